// ===== sv/ip_address_public_filter_defines.svh =====
// ----------------------------------------------------------------------------
// ip_address_public_filter_defines
// Assertion macros shared by the filter's checker.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_PUBLIC_FILTER_DEFINES_SVH
`define IP_ADDRESS_PUBLIC_FILTER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define IPAPF_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ipapf assertion failed");

// antecedent implies consequent after the delay given by dly
`define IPAPF_ASSERT_LATER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("ipapf assertion failed");

`endif

// ===== sv/ipapf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipapf_pkg
// Types and constants for the public IP address filter.
// ----------------------------------------------------------------------------
package ipapf_pkg;

   localparam logic [1:0] FAM_IPV4 = 2'd0;
   localparam logic [1:0] FAM_IPV6 = 2'd1;

   localparam int unsigned PIPE_DEPTH = 3;

   // IPv6 decode result
   typedef struct packed {
      logic embed_v4;   // address carries an IPv4 address
      logic native_bad; // unsafe under the native IPv6 rules
   } v6_class_type;

   // IPv4 range hits, grouped by how many octets they test
   typedef struct packed {
      logic hit_one;
      logic hit_two;
      logic hit_three;
   } v4_flags_type;

endpackage

// ===== sv/ipapf_v6_class.sv =====
// ----------------------------------------------------------------------------
// ipapf_v6_class
// Decodes an IPv6 address: embedded IPv4 forms and native unsafe blocks.
// ----------------------------------------------------------------------------
module ipapf_v6_class (
   input  logic                   [63:0] addr_high,
   input  logic                   [63:0] addr_low,
   output ipapf_pkg::v6_class_type       v6_class
);
   import ipapf_pkg::*;

   logic        hi_zero;
   logic        top_zero;
   logic        top_ffff;
   logic        v4_gt1;
   logic        nat64;
   logic [7:0]  b0;
   logic [7:0]  b1;
   logic [7:0]  b2;
   logic [7:0]  b3;
   logic [31:0] top32;

   always_comb begin
      b0       = addr_high[63:56];
      b1       = addr_high[55:48];
      b2       = addr_high[47:40];
      b3       = addr_high[39:32];
      top32    = addr_high[63:32];
      hi_zero  = (addr_high == 64'd0);
      top_zero = (addr_low[63:32] == 32'd0);
      top_ffff = (addr_low[63:32] == 32'h0000_ffff);
      v4_gt1   = |addr_low[31:1];
      nat64    = (addr_high == 64'h0064_ff9b_0000_0000);

      v6_class.embed_v4 = (hi_zero && top_ffff) || (hi_zero && top_zero && v4_gt1)
                       || (nat64 && top_zero);

      v6_class.native_bad = (hi_zero && top_zero && !v4_gt1)
                         || (b0[7:1] == 7'h7e)
                         || (b0 == 8'hfe && b1[7:6] == 2'b10)
                         || (b0 == 8'hff)
                         || (b0[7:5] != 3'b001)
                         || (top32 == 32'h2001_0000)
                         || (top32 == 32'h2001_0002)
                         || (top32 == 32'h2001_0db8)
                         || (b0 == 8'h20 && b1 == 8'h01 && b2 == 8'h00
                             && (b3[7:4] == 4'h1 || b3[7:4] == 4'h2))
                         || (b0 == 8'h20 && b1 == 8'h02);
   end

endmodule

// ===== sv/ipapf_v4_check.sv =====
// ----------------------------------------------------------------------------
// ipapf_v4_check
// Matches an IPv4 address against the special-purpose ranges.
// ----------------------------------------------------------------------------
module ipapf_v4_check (
   input  logic                   [31:0] v4_addr,
   output ipapf_pkg::v4_flags_type       v4_flags
);
   import ipapf_pkg::*;

   logic [7:0] o0;
   logic [7:0] o1;
   logic [7:0] o2;

   always_comb begin
      o0 = v4_addr[31:24];
      o1 = v4_addr[23:16];
      o2 = v4_addr[15:8];

      v4_flags.hit_one = (o0 == 8'd0) || (o0 == 8'd10) || (o0 == 8'd127)
                      || (o0 >= 8'd224);

      v4_flags.hit_two = (o0 == 8'd172 && o1[7:4] == 4'd1)
                      || (o0 == 8'd192 && o1 == 8'd168)
                      || (o0 == 8'd169 && o1 == 8'd254)
                      || (o0 == 8'd100 && o1[7:6] == 2'b01)
                      || (o0 == 8'd198 && o1[7:1] == 7'd9);

      v4_flags.hit_three = (o0 == 8'd192 && o1 == 8'd0 && (o2 == 8'd0 || o2 == 8'd2))
                        || (o0 == 8'd192 && o1 == 8'd88 && o2 == 8'd99)
                        || (o0 == 8'd198 && o1 == 8'd51 && o2 == 8'd100)
                        || (o0 == 8'd203 && o1 == 8'd0 && o2 == 8'd113);
   end

endmodule

// ===== sv/ip_address_public_filter.sv =====
// rsp_valid follows start through the register stages below. Throughput: one transaction per cycle.
// Three register stages: address decode, IPv4 range match, final select.
// busy is held low; the result strobe cannot be held off by the receiver.
// Synchronous active-high reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
// ip_address_public_filter
// Flags IP addresses that are non-public or of a disallowed family.
// ----------------------------------------------------------------------------
module ip_address_public_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_addr_family,
   input  logic [63:0] req_addr_high,
   input  logic [63:0] req_addr_low,
   output logic        rsp_valid,
   output logic        rsp_unsafe
);
   import ipapf_pkg::*;

   v6_class_type v6_class;
   v4_flags_type v4_flags;

   logic         s1_valid_in;
   logic         s1_use_v4_in;
   logic         s1_fixed_in;
   logic         s1_valid_ff;
   logic         s1_use_v4_ff;
   logic         s1_fixed_ff;
   logic [31:0]  s1_v4_addr_ff;

   logic         s2_valid_ff;
   logic         s2_use_v4_ff;
   logic         s2_fixed_ff;
   v4_flags_type s2_flags_ff;

   logic         rsp_unsafe_in;
   logic         rsp_valid_ff;
   logic         rsp_unsafe_ff;

   ipapf_v6_class u_v6_class (
      .addr_high (req_addr_high),
      .addr_low  (req_addr_low),
      .v6_class  (v6_class)
   );

   always_comb begin
      s1_valid_in = start && !busy;
      case (req_addr_family)
         FAM_IPV4: begin
            s1_use_v4_in = 1'b1;
            s1_fixed_in  = 1'b0;
         end
         FAM_IPV6: begin
            s1_use_v4_in = v6_class.embed_v4;
            s1_fixed_in  = v6_class.native_bad;
         end
         default: begin
            s1_use_v4_in = 1'b0;
            s1_fixed_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_use_v4_ff  <= s1_use_v4_in;
      s1_fixed_ff   <= s1_fixed_in;
      s1_v4_addr_ff <= req_addr_low[31:0];
   end

   ipapf_v4_check u_v4_check (
      .v4_addr  (s1_v4_addr_ff),
      .v4_flags (v4_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_use_v4_ff <= s1_use_v4_ff;
      s2_fixed_ff  <= s1_fixed_ff;
      s2_flags_ff  <= v4_flags;
   end

   always_comb begin
      if (s2_use_v4_ff) begin
         rsp_unsafe_in = s2_flags_ff.hit_one || s2_flags_ff.hit_two
                      || s2_flags_ff.hit_three;
      end else begin
         rsp_unsafe_in = s2_fixed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      rsp_unsafe_ff <= rsp_unsafe_in;
   end

   assign busy       = 1'b0;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_unsafe = rsp_unsafe_ff;

endmodule

// ===== sv/ipapf_checker.sv =====
// ----------------------------------------------------------------------------
// ipapf_checker
// Port-level checks on the filter's timing and family handling.
// ----------------------------------------------------------------------------
`include "ip_address_public_filter_defines.svh"

module ipapf_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_addr_family,
   input logic        rsp_valid,
   input logic        rsp_unsafe
);
   import ipapf_pkg::*;

   logic txn_accept;
   logic fam_other;

   assign txn_accept = start && !busy;
   assign fam_other  = (req_addr_family != FAM_IPV4) && (req_addr_family != FAM_IPV6);

   `IPAPF_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)
   `IPAPF_ASSERT_LATER(a_rsp_follows, clock, reset, txn_accept, PIPE_DEPTH, rsp_valid)
   `IPAPF_ASSERT_LATER(a_no_spurious, clock, reset, !txn_accept, PIPE_DEPTH, !rsp_valid)
   `IPAPF_ASSERT_LATER(a_other_unsafe, clock, reset, txn_accept && fam_other, PIPE_DEPTH, rsp_unsafe)

endmodule

bind ip_address_public_filter ipapf_checker u_ipapf_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_addr_family (req_addr_family),
   .rsp_valid       (rsp_valid),
   .rsp_unsafe      (rsp_unsafe)
);
